[rtl/spq_pkg.sv]
package spq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int PRIO_BITS_DEF = 16;

  localparam int VALUE_W  = 32;
  localparam int PRIO_W   = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctl_t;

endpackage

[rtl/spq_req_if.sv]
interface spq_req_if;
  import spq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [VALUE_W-1:0]  item_value;
  logic signed [PRIO_W-1:0]   item_priority;

  modport source (output valid, command, item_value, item_priority, input ready);
  modport sink   (input valid, command, item_value, item_priority, output ready);
endinterface

[rtl/spq_rsp_if.sv]
interface spq_rsp_if;
  import spq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  out_value;
  logic signed [PRIO_W-1:0]   out_priority;
  logic [STATUS_W-1:0]        status;
  logic                       queue_empty;
  logic [COUNT_W-1:0]         entry_count;

  modport source (output valid, out_value, out_priority, status, queue_empty, entry_count,
                  input ready);
  modport sink   (input valid, out_value, out_priority, status, queue_empty, entry_count,
                  output ready);
endinterface

[rtl/spq_cell.sv]
module spq_cell #(
  parameter int PRIORITY_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  spq_pkg::spq_ctl_t                  ctl,
  input  logic [spq_pkg::VALUE_W-1:0]        new_value,
  input  logic [PRIORITY_BITS-1:0]           new_prio,
  input  logic                               left_valid,
  input  logic                               left_ge,
  input  logic [spq_pkg::VALUE_W-1:0]        left_value,
  input  logic [PRIORITY_BITS-1:0]           left_prio,
  input  logic                               right_valid,
  input  logic [spq_pkg::VALUE_W-1:0]        right_value,
  input  logic [PRIORITY_BITS-1:0]           right_prio,
  output logic                               valid,
  output logic                               ge,
  output logic [spq_pkg::VALUE_W-1:0]        value,
  output logic [PRIORITY_BITS-1:0]           prio
);
  import spq_pkg::*;

  // entry stays in place when it ranks at or above the new item
  assign ge = valid && ($signed(prio) >= $signed(new_prio));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.enq && !ge) begin
      valid <= left_ge ? 1'b1 : left_valid;
    end else if (ctl.deq) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.enq && !ge) begin
      if (left_ge) begin
        value <= new_value;
        prio  <= new_prio;
      end else begin
        value <= left_value;
        prio  <= left_prio;
      end
    end else if (ctl.deq) begin
      value <= right_value;
      prio  <= right_prio;
    end
  end

endmodule

[rtl/sorted_priority_queue.sv]
// Bounded priority queue of DEPTH entries kept sorted by descending signed priority in a
// row of cells; equal priorities leave in arrival order. Each req item is an enqueue
// (command 0) or a dequeue (command 1) and yields exactly one rsp item with the dequeued
// entry (zero otherwise), a status (ok, dequeue on empty, enqueue dropped when full), the
// empty flag and the entry count after the operation. An item is first registered, then
// every cell compares against the broadcast priority and inserts, holds or shifts in
// parallel, independent of DEPTH; the next item is taken only once the last is applied.
// The rsp register is separate, so the next item is taken while a result waits; a stalled
// rsp channel holds the registered operation back from the cells until it drains.
module sorted_priority_queue #(
  parameter int DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic                     busy;
  logic                     op_cmd;
  logic [VALUE_W-1:0]       op_value;
  logic [PRIORITY_BITS-1:0] op_prio;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic                     fire;
  logic                     full;
  logic                     empty;
  logic                     enq_ok;
  logic                     deq_ok;
  spq_ctl_t                 ctl;

  logic [PRIORITY_BITS+PRIO_W-1:0] in_ext;
  logic [PRIORITY_BITS+PRIO_W-1:0] head_ext;
  logic [CW+COUNT_W-1:0]           count_ext;

  logic                     c_valid [DEPTH];
  logic                     c_ge    [DEPTH];
  logic [VALUE_W-1:0]       c_value [DEPTH];
  logic [PRIORITY_BITS-1:0] c_prio  [DEPTH];

  assign in_ext    = {{PRIORITY_BITS{1'b0}}, req.item_priority};
  assign req.ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.valid && req.ready) begin
      busy <= 1'b1;
    end else if (fire) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_cmd   <= req.command;
      op_value <= req.item_value;
      op_prio  <= in_ext[PRIORITY_BITS-1:0];
    end
  end

  assign fire   = busy && (!rsp.valid || rsp.ready);
  assign full   = c_valid[DEPTH-1];
  assign empty  = !c_valid[0];
  assign enq_ok = fire && (op_cmd == CMD_ENQ) && !full;
  assign deq_ok = fire && (op_cmd == CMD_DEQ) && !empty;
  assign ctl    = '{enq: enq_ok, deq: deq_ok};

  always_comb begin
    count_next = count;
    if (enq_ok) begin
      count_next = count + 1'b1;
    end else if (deq_ok) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                     l_valid;
      logic                     l_ge;
      logic [VALUE_W-1:0]       l_value;
      logic [PRIORITY_BITS-1:0] l_prio;
      logic                     r_valid;
      logic [VALUE_W-1:0]       r_value;
      logic [PRIORITY_BITS-1:0] r_prio;

      if (i == 0) begin : g_head
        assign l_valid = 1'b0;
        assign l_ge    = 1'b1;
        assign l_value = '0;
        assign l_prio  = '0;
      end else begin : g_mid
        assign l_valid = c_valid[i-1];
        assign l_ge    = c_ge[i-1];
        assign l_value = c_value[i-1];
        assign l_prio  = c_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign r_valid = 1'b0;
        assign r_value = '0;
        assign r_prio  = '0;
      end else begin : g_body
        assign r_valid = c_valid[i+1];
        assign r_value = c_value[i+1];
        assign r_prio  = c_prio[i+1];
      end

      spq_cell #(
        .PRIORITY_BITS(PRIORITY_BITS)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .new_value   (op_value),
        .new_prio    (op_prio),
        .left_valid  (l_valid),
        .left_ge     (l_ge),
        .left_value  (l_value),
        .left_prio   (l_prio),
        .right_valid (r_valid),
        .right_value (r_value),
        .right_prio  (r_prio),
        .valid       (c_valid[i]),
        .ge          (c_ge[i]),
        .value       (c_value[i]),
        .prio        (c_prio[i])
      );
    end
  endgenerate

  assign head_ext  = {{PRIO_W{1'b0}}, c_prio[0]};
  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.out_value    <= deq_ok ? c_value[0] : '0;
      rsp.out_priority <= deq_ok ? head_ext[PRIO_W-1:0] : '0;
      if (op_cmd == CMD_ENQ) begin
        rsp.status <= full ? ST_FULL : ST_OK;
      end else begin
        rsp.status <= empty ? ST_EMPTY : ST_OK;
      end
      rsp.queue_empty <= (count_next == '0);
      rsp.entry_count <= count_ext[COUNT_W-1:0];
    end
  end

endmodule
